// ----- rtl/mstte_pkg.sv -----
// shared types and constants for the software timer engine
`timescale 1ns / 1ps
package mstte_pkg;
	localparam int SLOTS = 8;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int TABLES = 3;
	localparam int ADDR_W = SLOT_W + 2;

	localparam logic [2:0] OP_TICK = 3'd0;
	localparam logic [2:0] OP_TO_START = 3'd1;
	localparam logic [2:0] OP_TO_STOP = 3'd2;
	localparam logic [2:0] OP_PER_START = 3'd3;
	localparam logic [2:0] OP_PER_STOP = 3'd4;
	localparam logic [2:0] OP_CNT_START = 3'd5;
	localparam logic [2:0] OP_CNT_STOP = 3'd6;
	localparam logic [2:0] OP_NONE = 3'd7;

	localparam logic [1:0] TBL_TIMEOUT = 2'd0;
	localparam logic [1:0] TBL_PERIODIC = 2'd1;
	localparam logic [1:0] TBL_COUNTED = 2'd2;

	localparam logic EV_FIRE = 1'b0;
	localparam logic EV_FULL = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIND,
		ST_APPLY,
		ST_EMIT,
		ST_WAIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture input transaction
		logic tick_inc;  // advance the tick counter
		logic scan_clr;  // reset slot pointer
		logic scan_adv;  // step slot pointer
		logic find_step; // compare one slot during lookup
		logic apply;     // perform start or stop update
		logic fire_slot; // update current slot and stage a fire result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last; // pointer on the final slot
		logic slot_due;  // current slot valid and due
		logic find_last; // lookup on last slot
		logic has_result; // start produced a result
	} sts_t;
endpackage

// ----- rtl/mstte_ctrl.sv -----
// controller sequencing tick scans and start/stop lookups
`timescale 1ns / 1ps
module mstte_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input logic [2:0] op_q_i,
	output mstte_pkg::cmd_t cmd,
	input mstte_pkg::sts_t sts
);
	import mstte_pkg::*;

	state_t state_q, state_d;
	logic ret_scan_q, ret_scan_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_scan_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_scan_q <= ret_scan_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		ret_scan_d = ret_scan_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (op_q_i == OP_TICK) state_d = ST_SCAN;
				else state_d = ST_FIND;
			end
			ST_SCAN: begin
				if (sts.slot_due) begin
					state_d = ST_EMIT;
					ret_scan_d = 1'b1;
				end else if (sts.scan_last) state_d = ST_IDLE;
			end
			ST_FIND: begin
				if (sts.find_last) state_d = ST_APPLY;
			end
			ST_APPLY: begin
				if (sts.has_result) begin
					state_d = ST_EMIT;
					ret_scan_d = 1'b0;
				end else state_d = ST_IDLE;
			end
			ST_EMIT: begin
				if (out_ready) begin
					if (ret_scan_q && !sts.scan_last) state_d = ST_SCAN;
					else state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_WAIT: begin
				cmd.scan_clr = 1'b1;
				cmd.tick_inc = (op_q_i == OP_TICK);
			end
			ST_SCAN: begin
				cmd.fire_slot = sts.slot_due;
				cmd.scan_adv = !sts.slot_due;
			end
			ST_FIND: begin
				cmd.find_step = 1'b1;
				cmd.scan_adv = !sts.find_last;
			end
			ST_APPLY: cmd.apply = 1'b1;
			ST_EMIT: begin
				out_valid = 1'b1;
				cmd.scan_adv = out_ready && ret_scan_q;
			end
			default: ;
		endcase
	end
endmodule

// ----- rtl/mstte_dp.sv -----
// datapath: slot tables, tick counter, lookup and result registers
`timescale 1ns / 1ps
module mstte_dp (
	input logic clk,
	input logic arst_n,
	input logic [2:0] op,
	input logic [7:0] task_id,
	input logic [15:0] period_ms,
	input logic [7:0] repeat_count,
	input mstte_pkg::cmd_t cmd,
	output mstte_pkg::sts_t sts,
	output logic [2:0] op_q_o,
	output logic event_kind,
	output logic [1:0] table_kind,
	output logic [7:0] fired_task,
	output logic last_result
);
	import mstte_pkg::*;

	localparam int NS = TABLES * SLOTS;

	logic [2:0] op_q;
	logic [7:0] task_q, num_q;
	logic [15:0] per_q;
	logic [31:0] tick_q;
	logic [NS-1:0] valid_q;
	logic [7:0] stask_q [NS];
	logic [31:0] start_q [NS];
	logic [15:0] speriod_q [NS];
	logic [7:0] rem_q [SLOTS];
	logic [ADDR_W-1:0] ptr_q;
	logic match_hit_q, free_hit_q;
	logic [SLOT_W-1:0] match_q, free_q;
	logic ev_q, last_q;
	logic [1:0] tbl_q;
	logic [7:0] ftask_q;

	logic [1:0] tbl_sel;
	logic [ADDR_W-1:0] base;
	logic [ADDR_W-1:0] cur;
	logic [SLOT_W-1:0] sidx;
	logic [31:0] elapsed;
	logic cur_due;
	logic [ADDR_W-1:0] last_slot;
	logic remaining_due;

	assign op_q_o = op_q;
	assign sidx = ptr_q[SLOT_W-1:0];
	assign cur = ptr_q;
	assign elapsed = tick_q - start_q[cur];
	assign cur_due = valid_q[cur] && (elapsed >= {16'd0, speriod_q[cur]});
	assign last_slot = ADDR_W'(NS - 1);

	// table selected by a start or stop op
	always_comb begin
		case (op_q)
			OP_TO_START, OP_TO_STOP: tbl_sel = TBL_TIMEOUT;
			OP_PER_START, OP_PER_STOP: tbl_sel = TBL_PERIODIC;
			OP_CNT_START, OP_CNT_STOP: tbl_sel = TBL_COUNTED;
			default: tbl_sel = TBL_TIMEOUT;
		endcase
		base = ADDR_W'(32'(tbl_sel) * SLOTS);
	end

	// any later slot due; decides which fire is final
	always_comb begin
		remaining_due = 1'b0;
		for (int k = 0; k < NS; k++) begin
			if (ADDR_W'(k) > cur && valid_q[k] &&
				((tick_q - start_q[k]) >= {16'd0, speriod_q[k]}))
				remaining_due = 1'b1;
		end
	end

	// start/stop effect
	logic act_emit, act_ev;
	logic act_free, act_put;
	logic [SLOT_W-1:0] put_idx;
	logic [15:0] put_per;
	logic same;
	always_comb begin
		act_emit = 1'b0;
		act_ev = EV_FIRE;
		act_free = 1'b0;
		act_put = 1'b0;
		put_idx = free_q;
		put_per = per_q;
		same = match_hit_q &&
			speriod_q[base + ADDR_W'(match_q)] == per_q;
		case (op_q)
			OP_TO_START: begin
				if (per_q == 16'd1) put_per = 16'd2;
				if (!match_hit_q) begin
					if (free_hit_q) act_put = 1'b1;
					else begin
						act_emit = 1'b1;
						act_ev = EV_FULL;
					end
				end
			end
			OP_PER_START: begin
				if (!same) begin
					act_free = match_hit_q;
					if (free_hit_q || match_hit_q) begin
						act_put = 1'b1;
						act_emit = 1'b1;
						if (!free_hit_q || (match_hit_q && match_q < free_q))
							put_idx = match_q;
					end else begin
						act_emit = 1'b1;
						act_ev = EV_FULL;
					end
				end
			end
			OP_CNT_START: begin
				if (num_q == 8'd1) act_emit = 1'b1;
				else if (num_q != 8'd0 && !(same && rem_q[match_q] == num_q)) begin
					act_free = match_hit_q;
					if (free_hit_q || match_hit_q) begin
						act_put = 1'b1;
						act_emit = 1'b1;
						if (!free_hit_q || (match_hit_q && match_q < free_q))
							put_idx = match_q;
					end else begin
						act_emit = 1'b1;
						act_ev = EV_FULL;
					end
				end
			end
			OP_TO_STOP, OP_PER_STOP, OP_CNT_STOP: act_free = match_hit_q;
			default: ;
		endcase
	end

	assign sts.scan_last = (cur == last_slot);
	assign sts.slot_due = cur_due;
	assign sts.find_last = (sidx == SLOT_W'(SLOTS - 1));
	assign sts.has_result = act_emit;

	// tick counter, pointer and lookup; input capture below
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			ptr_q <= '0;
			match_hit_q <= 1'b0;
			free_hit_q <= 1'b0;
			match_q <= '0;
			free_q <= '0;
		end else begin
			if (cmd.tick_inc) tick_q <= tick_q + 32'd1;
			if (cmd.scan_clr) begin
				ptr_q <= (op_q == OP_TICK) ? '0 : base;
				match_hit_q <= 1'b0;
				free_hit_q <= 1'b0;
			end else if (cmd.scan_adv) ptr_q <= ptr_q + 1'b1;
			if (cmd.find_step) begin
				if (!match_hit_q && valid_q[cur] && stask_q[cur] == task_q) begin
					match_hit_q <= 1'b1;
					match_q <= sidx;
				end
				if (!free_hit_q && !valid_q[cur]) begin
					free_hit_q <= 1'b1;
					free_q <= sidx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			task_q <= task_id;
			per_q <= period_ms;
			num_q <= repeat_count;
		end
	end

	// slot tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= '0;
		else if (cmd.fire_slot) begin
			if (cur < ADDR_W'(SLOTS)) valid_q[cur] <= 1'b0;
			else if (cur >= ADDR_W'(2 * SLOTS) && rem_q[sidx] == 8'd1)
				valid_q[cur] <= 1'b0;
		end else if (cmd.apply) begin
			if (act_free) valid_q[base + ADDR_W'(match_q)] <= 1'b0;
			if (act_put) valid_q[base + ADDR_W'(put_idx)] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fire_slot) begin
			start_q[cur] <= tick_q;
			if (cur >= ADDR_W'(2 * SLOTS)) rem_q[sidx] <= rem_q[sidx] - 8'd1;
		end else if (cmd.apply) begin
			if (op_q == OP_TO_START && match_hit_q)
				start_q[base + ADDR_W'(match_q)] <= tick_q;
			if (act_put) begin
				stask_q[base + ADDR_W'(put_idx)] <= task_q;
				start_q[base + ADDR_W'(put_idx)] <= tick_q;
				speriod_q[base + ADDR_W'(put_idx)] <= put_per;
				if (op_q == OP_CNT_START) rem_q[put_idx] <= num_q - 8'd1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.fire_slot) begin
			ev_q <= EV_FIRE;
			tbl_q <= cur[ADDR_W-1:SLOT_W];
			ftask_q <= stask_q[cur];
			last_q <= !remaining_due;
		end else if (cmd.apply) begin
			ev_q <= act_ev;
			tbl_q <= tbl_sel;
			ftask_q <= task_q;
			last_q <= 1'b1;
		end
	end

	assign event_kind = ev_q;
	assign table_kind = tbl_q;
	assign fired_task = ftask_q;
	assign last_result = last_q;
endmodule

// ----- rtl/multi_slot_software_timer_engine_core.sv -----
// top level of the multi-slot software timer engine
// a tick runs a setup state and then scans all 24 slots in turn; each fire result
// adds an emit state, which the receiver can stall
// start and stop run a setup state, an 8-slot lookup and an update state, then
// an emit state when a result is sent; one transaction at a time, input taken when idle
// reset clears the tick counter and all slot valid bits
`timescale 1ns / 1ps
module multi_slot_software_timer_engine_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [2:0] op,
	input logic [7:0] task_id,
	input logic [15:0] period_ms,
	input logic [7:0] repeat_count,
	output logic out_valid,
	input logic out_ready,
	output logic event_kind,
	output logic [1:0] table_kind,
	output logic [7:0] fired_task,
	output logic last_result
);
	import mstte_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [2:0] op_q;

	// sequencing
	mstte_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .op_q_i(op_q),
		.cmd(cmd), .sts(sts)
	);

	// tables and arithmetic
	mstte_dp u_dp (
		.clk(clk), .arst_n(arst_n), .op(op), .task_id(task_id),
		.period_ms(period_ms), .repeat_count(repeat_count), .cmd(cmd),
		.sts(sts), .op_q_o(op_q), .event_kind(event_kind),
		.table_kind(table_kind), .fired_task(fired_task),
		.last_result(last_result)
	);
endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for the multi-slot software timer engine
`timescale 1ns / 1ps
module tb_top;
	import mstte_pkg::*;

	localparam int NSLOT = SLOTS;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic kind;
		logic [1:0] tbl;
		logic [7:0] task_no;
		logic last;
	} fire_t;

	typedef struct {
		bit used;
		bit [7:0] task_no;
		bit [31:0] origin;
		bit [15:0] span;
	} timer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] op = OP_TICK;
	logic [7:0] task_id = '0;
	logic [15:0] period_ms = '0;
	logic [7:0] repeat_count = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic event_kind;
	logic [1:0] table_kind;
	logic [7:0] fired_task;
	logic last_result;

	// model state
	timer_t tmo_tbl[NSLOT];
	timer_t per_tbl[NSLOT];
	timer_t cnt_tbl[NSLOT];
	bit [7:0] runs_left[NSLOT];
	bit [31:0] now_ms;
	fire_t pending_fires[$];

	int fail_cnt = 0;
	int idle_cycles = 0;
	bit hold_off = 1'b0;

	multi_slot_software_timer_engine_core DUT (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int lookup(ref timer_t t[NSLOT], input bit [7:0] id);
		for (int i = 0; i < NSLOT; i++)
			if (t[i].used && t[i].task_no == id)
				return i;
		return -1;
	endfunction

	function automatic int free_slot(ref timer_t t[NSLOT]);
		for (int i = 0; i < NSLOT; i++)
			if (!t[i].used)
				return i;
		return -1;
	endfunction

	function automatic bit expired(timer_t s);
		bit [31:0] el;
		el = now_ms - s.origin;
		return el >= {16'd0, s.span};
	endfunction

	// compute the fire results one transaction causes
	task automatic predict_fires(bit [2:0] code, bit [7:0] id, bit [15:0] per, bit [7:0] num);
		fire_t res[$];
		int i;
		bit [15:0] p;
		case (code)
			OP_TICK: begin
				now_ms++;
				for (int k = 0; k < NSLOT; k++)
					if (tmo_tbl[k].used && expired(tmo_tbl[k])) begin
						tmo_tbl[k].used = 0;
						res.push_back('{EV_FIRE, TBL_TIMEOUT, tmo_tbl[k].task_no, 1'b0});
					end
				for (int k = 0; k < NSLOT; k++)
					if (per_tbl[k].used && expired(per_tbl[k])) begin
						per_tbl[k].origin = now_ms;
						res.push_back('{EV_FIRE, TBL_PERIODIC, per_tbl[k].task_no, 1'b0});
					end
				for (int k = 0; k < NSLOT; k++)
					if (cnt_tbl[k].used && expired(cnt_tbl[k])) begin
						cnt_tbl[k].origin = now_ms;
						res.push_back('{EV_FIRE, TBL_COUNTED, cnt_tbl[k].task_no, 1'b0});
						runs_left[k] = runs_left[k] - 8'd1;
						if (runs_left[k] == 0)
							cnt_tbl[k].used = 0;
					end
			end
			OP_TO_START: begin
				p = (per == 16'd1) ? 16'd2 : per;
				i = lookup(tmo_tbl, id);
				if (i >= 0)
					tmo_tbl[i].origin = now_ms;
				else begin
					i = free_slot(tmo_tbl);
					if (i >= 0)
						tmo_tbl[i] = '{1'b1, id, now_ms, p};
					else
						res.push_back('{EV_FULL, TBL_TIMEOUT, id, 1'b0});
				end
			end
			OP_PER_START: begin
				i = lookup(per_tbl, id);
				if (!(i >= 0 && per_tbl[i].span == per)) begin
					if (i >= 0)
						per_tbl[i].used = 0;
					i = free_slot(per_tbl);
					if (i >= 0) begin
						per_tbl[i] = '{1'b1, id, now_ms, per};
						res.push_back('{EV_FIRE, TBL_PERIODIC, id, 1'b0});
					end else
						res.push_back('{EV_FULL, TBL_PERIODIC, id, 1'b0});
				end
			end
			OP_CNT_START: begin
				if (num == 8'd1)
					res.push_back('{EV_FIRE, TBL_COUNTED, id, 1'b0});
				else if (num != 8'd0) begin
					i = lookup(cnt_tbl, id);
					if (!(i >= 0 && runs_left[i] == num && cnt_tbl[i].span == per)) begin
						if (i >= 0)
							cnt_tbl[i].used = 0;
						i = free_slot(cnt_tbl);
						if (i >= 0) begin
							cnt_tbl[i] = '{1'b1, id, now_ms, per};
							runs_left[i] = num - 8'd1;
							res.push_back('{EV_FIRE, TBL_COUNTED, id, 1'b0});
						end else
							res.push_back('{EV_FULL, TBL_COUNTED, id, 1'b0});
					end
				end
			end
			OP_TO_STOP: begin
				i = lookup(tmo_tbl, id);
				if (i >= 0) tmo_tbl[i].used = 0;
			end
			OP_PER_STOP: begin
				i = lookup(per_tbl, id);
				if (i >= 0) per_tbl[i].used = 0;
			end
			OP_CNT_STOP: begin
				i = lookup(cnt_tbl, id);
				if (i >= 0) cnt_tbl[i].used = 0;
			end
			default: ;
		endcase
		if (res.size() > 0)
			res[res.size() - 1].last = 1'b1;
		foreach (res[k])
			pending_fires.push_back(res[k]);
	endtask

	// send one transaction, predicting at acceptance
	task automatic send_item(bit [2:0] code, bit [7:0] id, bit [15:0] per, bit [7:0] num);
		@(negedge clk);
		op <= code;
		task_id <= id;
		period_ms <= per;
		repeat_count <= num;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_fires(code, id, per, num);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// sender gaps between bursts
	task automatic maybe_gap(inout int burst);
		if (burst == 0) begin
			burst = $urandom_range(1, 12);
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
		burst--;
	endtask

	task automatic drain();
		while (pending_fires.size() > 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic test_directed();
		send_item(OP_TICK, 8'h00, 16'h0000, 8'h00);
		send_item(OP_TO_START, 8'hFF, 16'd1, 8'h00);
		send_item(OP_TO_START, 8'h00, 16'd0, 8'hFF);
		send_item(OP_TO_START, 8'hFF, 16'hFFFF, 8'h00);
		send_item(OP_PER_START, 8'hA5, 16'd0, 8'h00);
		send_item(OP_PER_START, 8'hA5, 16'd0, 8'h00);
		send_item(OP_PER_START, 8'hA5, 16'd3, 8'h00);
		send_item(OP_CNT_START, 8'h5A, 16'd1, 8'd0);
		send_item(OP_CNT_START, 8'h5A, 16'd1, 8'd1);
		send_item(OP_CNT_START, 8'h5A, 16'd1, 8'd3);
		send_item(OP_CNT_START, 8'h5A, 16'd1, 8'd3);
		send_item(OP_CNT_START, 8'h3C, 16'hFFFF, 8'hFF);
		for (int k = 0; k < 5; k++)
			send_item(OP_TICK, 8'h00, 16'h0000, 8'h00);
		send_item(OP_TO_STOP, 8'h77, 16'h0, 8'h0);
		send_item(OP_NONE, 8'hFF, 16'hFFFF, 8'hFF);
		send_item(OP_PER_STOP, 8'hA5, 16'h0, 8'h0);
		send_item(OP_CNT_STOP, 8'h3C, 16'h0, 8'h0);
		send_item(OP_TO_STOP, 8'hFF, 16'h0, 8'h0);
		// sender pauses until every expected result is in
		drain();
	endtask

	task automatic test_full_tables();
		for (int k = 0; k < 9; k++)
			send_item(OP_PER_START, 8'(8'h10 + k), 16'd2, 8'h00);
		for (int k = 0; k < 9; k++)
			send_item(OP_TO_START, 8'(8'h20 + k), 16'd4, 8'h00);
		for (int k = 0; k < 9; k++)
			send_item(OP_CNT_START, 8'(8'h30 + k), 16'd0, 8'd2);
		// long receiver hold-off while ticks keep coming
		hold_off = 1'b1;
		for (int k = 0; k < 6; k++)
			send_item(OP_TICK, 8'h00, 16'h0000, 8'h00);
		for (int k = 0; k < 8; k++) begin
			send_item(OP_TO_STOP, 8'(8'h20 + k), 16'h0, 8'h0);
			send_item(OP_PER_STOP, 8'(8'h10 + k), 16'h0, 8'h0);
		end
		drain();
	endtask

	task automatic test_random();
		int burst = 0;
		bit [2:0] code;
		bit [7:0] id;
		bit [15:0] per;
		bit [7:0] num;
		for (int n = 0; n < 40; n++) begin
			maybe_gap(burst);
			code = 3'($urandom_range(0, 9));
			if (code > OP_CNT_STOP || $urandom_range(0, 3) == 0)
				code = OP_TICK;
			// few task ids so stops and re-arms hit, with occasional wide ones
			id = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
			per = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
			num = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
			if ($urandom_range(0, 30) == 0)
				code = OP_NONE;
			send_item(code, id, per, num);
		end
		drain();
	endtask

	// receiver stall pattern plus the long hold-off
	initial begin
		int held;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				for (held = 0; held < 300; held++)
					@(negedge clk);
				hold_off = 1'b0;
			end
			out_ready <= ($urandom_range(0, 15) < 3) ? 1'b0 : 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		fire_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_fires.size() == 0) begin
				fail_cnt++;
				$display("%0t unexpected result kind=%0d tbl=%0d task=%0d last=%0d",
					$time, event_kind, table_kind, fired_task, last_result);
			end else begin
				want = pending_fires.pop_front();
				if (want != {event_kind, table_kind, fired_task, last_result}) begin
					fail_cnt++;
					$display("%0t mismatch exp kind=%0d tbl=%0d task=%0d last=%0d",
						$time, want.kind, want.tbl, want.task_no, want.last);
					$display("%0t          got kind=%0d tbl=%0d task=%0d last=%0d",
						$time, event_kind, table_kind, fired_task, last_result);
				end
			end
		end
	end

	// watchdog on stalled progress
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("multi_slot_software_timer_engine_core regression: fail");
			$finish;
		end
	end

	initial begin
		now_ms = 0;
		foreach (tmo_tbl[k]) begin
			tmo_tbl[k] = '{0, 0, 0, 0};
			per_tbl[k] = '{0, 0, 0, 0};
			cnt_tbl[k] = '{0, 0, 0, 0};
			runs_left[k] = 0;
		end
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_full_tables();
		test_random();
		if (pending_fires.size() != 0)
			fail_cnt++;
		if (fail_cnt == 0)
			$display("multi_slot_software_timer_engine_core regression: pass");
		else
			$display("multi_slot_software_timer_engine_core regression: fail");
		$finish;
	end
endmodule
